// ===== design/aecg_pkg.sv =====
// Package for the argmax error counter: widths, limits, register indexes,
// payload structs and the row position struct shared by the modules.
// No dependencies.
package aecg_pkg;

    localparam int SCORE_W = 16;
    localparam int GRAD_W  = SCORE_W + 1;
    localparam int CLASS_W = 10;
    localparam int CFG_W   = 11;
    localparam int IDX_W   = 2;

    localparam logic [CFG_W-1:0] MAX_ROW_LENGTH = 11'd1024;
    localparam logic [CFG_W-1:0] MAX_BATCH_ROWS = 11'd1024;
    localparam logic [CFG_W-1:0] COUNT_MAX      = 11'h7FF;

    localparam logic [IDX_W-1:0] REG_ROW_LENGTH = 2'd0;
    localparam logic [IDX_W-1:0] REG_BATCH_ROWS = 2'd1;

    typedef struct packed {
        logic signed [SCORE_W-1:0] output_score;
        logic signed [SCORE_W-1:0] target_score;
    } t_in_item;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gradient;
        logic                     last_of_row;
        logic [CLASS_W-1:0]       predicted_class;
        logic [CLASS_W-1:0]       target_class;
        logic                     row_correct;
        logic [CFG_W-1:0]         error_count;
        logic                     last_of_batch;
    } t_out_item;

    // Row position for the item now in the compute stage.
    typedef struct packed {
        logic               first;
        logic               row_end;
        logic               batch_end;
        logic [CLASS_W-1:0] elem_idx;
        logic [CFG_W-1:0]   count;
    } t_pos;

    // Map a zero length to one and clip at the maximum.
    function automatic logic [CFG_W-1:0] clamp_len(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] maxv);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = {{(CFG_W-1){1'b0}}, 1'b1};
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== design/argmax_error_count_with_gradient.sv =====
// Argmax classification error counter with gradient output.
// An accepted item goes into the input register and then into the result register that drives o_out.
// Throughput: one item per cycle; on a result stall the input register takes one
// more item, then o_in_ready drops until the result is taken.
// Reset (synchronous, active low): empties both stages, clears counters and
// argmax state, sets row_length and batch_rows to 1024.
module argmax_error_count_with_gradient (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  aecg_pkg::t_in_item             i_in,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output aecg_pkg::t_out_item            o_out,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [aecg_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [aecg_pkg::CFG_W-1:0]     i_cfg_data
);

    // Configuration registers.
    logic [aecg_pkg::CFG_W-1:0] r_row_length;
    logic [aecg_pkg::CFG_W-1:0] r_batch_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= aecg_pkg::MAX_ROW_LENGTH;
            r_batch_rows <= aecg_pkg::MAX_BATCH_ROWS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                aecg_pkg::REG_ROW_LENGTH: r_row_length <= i_cfg_data;
                aecg_pkg::REG_BATCH_ROWS: r_batch_rows <= i_cfg_data;
                default: ; // drop writes to unknown indexes
            endcase
        end
    end

    // Input stage: holds the accepted item until the result register frees up.
    logic                 r_in_valid;
    aecg_pkg::t_in_item   r_in;
    logic                 r_out_valid;
    aecg_pkg::t_out_item  r_out, n_out;
    logic                 advance;

    // Move the item forward when the result register is empty or being drained.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Compute stage: row position, two argmax trackers, gradient.
    aecg_pkg::t_pos               pos;
    logic [aecg_pkg::CLASS_W-1:0] pred_idx, targ_idx;
    logic                         correct;

    assign correct = (pred_idx == targ_idx);

    aecg_rowctl u_rowctl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_row_length (r_row_length),
        .i_batch_rows (r_batch_rows),
        .i_correct    (correct),
        .o_pos        (pos)
    );

    aecg_argmax u_argmax_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_first    (pos.first),
        .i_elem_idx (pos.elem_idx),
        .i_score    (r_in.output_score),
        .o_best_idx (pred_idx)
    );

    aecg_argmax u_argmax_tgt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_first    (pos.first),
        .i_elem_idx (pos.elem_idx),
        .i_score    (r_in.target_score),
        .o_best_idx (targ_idx)
    );

    always_comb begin
        n_out.gradient        = {r_in.target_score[aecg_pkg::SCORE_W-1], r_in.target_score}
                              - {r_in.output_score[aecg_pkg::SCORE_W-1], r_in.output_score};
        n_out.last_of_row     = pos.row_end;
        n_out.predicted_class = pos.row_end ? pred_idx : '0;
        n_out.target_class    = pos.row_end ? targ_idx : '0;
        n_out.row_correct     = pos.row_end && correct;
        n_out.error_count     = pos.count;
        n_out.last_of_batch   = pos.batch_end;
    end

    // Result register: hold until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef NO_ASSERTIONS
    // A batch ends only at a row end.
    a_batch_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out.last_of_batch || o_out.last_of_row))
        else $error("last_of_batch without last_of_row");

    // Row results are zero away from a row end.
    a_row_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.last_of_row) |->
        (!o_out.row_correct && o_out.predicted_class == '0 && o_out.target_class == '0))
        else $error("row result fields set mid row");

    // A stalled item stays in the input register unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
        else $error("input stage lost a stalled item");

    // Every forwarded item shows up as a valid result.
    a_advance_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("forwarded item missing from result register");
`endif

endmodule

// ===== design/aecg_argmax.sv =====
// Running argmax of one score vector; the first maximum wins on ties.
// Depends on aecg_pkg.
module aecg_argmax (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_advance,
    input  logic                              i_first,
    input  logic [aecg_pkg::CLASS_W-1:0]      i_elem_idx,
    input  logic signed [aecg_pkg::SCORE_W-1:0] i_score,
    output logic [aecg_pkg::CLASS_W-1:0]      o_best_idx
);

    logic signed [aecg_pkg::SCORE_W-1:0] r_best, n_best;
    logic [aecg_pkg::CLASS_W-1:0]        r_idx, n_idx;

    always_comb begin
        n_best = r_best;
        n_idx  = r_idx;
        if (i_first) begin
            n_best = i_score;
            n_idx  = '0;
        end else if (i_score > r_best) begin
            n_best = i_score;
            n_idx  = i_elem_idx;
        end
    end

    assign o_best_idx = n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
            r_idx  <= '0;
        end else if (i_advance) begin
            r_best <= n_best;
            r_idx  <= n_idx;
        end
    end

endmodule

// ===== design/aecg_rowctl.sv =====
// Element, row and mismatch counters with row and batch end detection.
// Depends on aecg_pkg.
module aecg_rowctl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic [aecg_pkg::CFG_W-1:0]    i_row_length,
    input  logic [aecg_pkg::CFG_W-1:0]    i_batch_rows,
    input  logic                          i_correct,
    output aecg_pkg::t_pos                o_pos
);

    logic [aecg_pkg::CLASS_W-1:0] r_elem;
    logic [aecg_pkg::CLASS_W-1:0] r_row;
    logic [aecg_pkg::CFG_W-1:0]   r_cnt;

    logic [aecg_pkg::CFG_W-1:0] len, rows, elem_next, row_next, cnt_out;
    logic                       row_end, batch_end;

    always_comb begin
        len       = aecg_pkg::clamp_len(i_row_length, aecg_pkg::MAX_ROW_LENGTH);
        rows      = aecg_pkg::clamp_len(i_batch_rows, aecg_pkg::MAX_BATCH_ROWS);
        elem_next = {1'b0, r_elem} + 1'b1;
        row_next  = {1'b0, r_row} + 1'b1;
        row_end   = (elem_next >= len);
        batch_end = row_end && (row_next >= rows);
        cnt_out   = r_cnt;
        if (row_end && !i_correct && (r_cnt != aecg_pkg::COUNT_MAX)) begin
            cnt_out = r_cnt + 1'b1;
        end
    end

    assign o_pos.first     = (r_elem == '0);
    assign o_pos.row_end   = row_end;
    assign o_pos.batch_end = batch_end;
    assign o_pos.elem_idx  = r_elem;
    assign o_pos.count     = cnt_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem <= '0;
            r_row  <= '0;
            r_cnt  <= '0;
        end else if (i_advance) begin
            if (row_end) begin
                r_elem <= '0;
                if (batch_end) begin
                    r_row <= '0;
                    r_cnt <= '0;
                end else begin
                    r_row <= row_next[aecg_pkg::CLASS_W-1:0];
                    r_cnt <= cnt_out;
                end
            end else begin
                r_elem <= elem_next[aecg_pkg::CLASS_W-1:0];
            end
        end
    end

endmodule

// ===== tb/argmax_error_checker.sv =====
`timescale 1ns / 100ps
// Result checker for argmax_error_count_with_gradient: watches the item, result
// and register write ports, predicts every result and compares it.
// Depends on aecg_pkg.
module argmax_error_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  aecg_pkg::t_in_item         i_in,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  aecg_pkg::t_out_item        i_out,
    input  logic                       i_cfg_we,
    input  logic [aecg_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [aecg_pkg::CFG_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int                         REPORT_LIMIT = 10;
    localparam logic [aecg_pkg::CFG_W-1:0] LEN_AT_RESET = 11'd1024;

    // Shadow registers and row/batch tracking state.
    logic [aecg_pkg::CFG_W-1:0] row_len_reg    = LEN_AT_RESET;
    logic [aecg_pkg::CFG_W-1:0] batch_rows_reg = LEN_AT_RESET;
    int                         best_out_score = 0;
    int                         best_tgt_score = 0;
    int unsigned                best_out_pos   = 0;
    int unsigned                best_tgt_pos   = 0;
    int unsigned                elem_pos       = 0;
    int unsigned                row_pos        = 0;
    int unsigned                miss_rows      = 0;

    aecg_pkg::t_out_item results_due[$];
    int                  fail_count = 0;
    int                  due_count  = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = due_count;

    function automatic int unsigned effective_len(input logic [aecg_pkg::CFG_W-1:0] v,
                                                  input logic [aecg_pkg::CFG_W-1:0] cap);
        if (v == '0) return 1;
        if (v > cap) return cap;
        return v;
    endfunction

    // Advance the argmax state by one element and form its result.
    function automatic aecg_pkg::t_out_item step_argmax(input aecg_pkg::t_in_item it);
        aecg_pkg::t_out_item r;
        int                  o;
        int                  t;
        int                  diff;
        int unsigned         len;
        int unsigned         rows;
        logic                row_done;
        logic                batch_done;
        o          = $signed(it.output_score);
        t          = $signed(it.target_score);
        len        = effective_len(row_len_reg, aecg_pkg::MAX_ROW_LENGTH);
        rows       = effective_len(batch_rows_reg, aecg_pkg::MAX_BATCH_ROWS);
        batch_done = 1'b0;
        r          = '0;
        if (elem_pos == 0) begin
            best_out_score = o;
            best_tgt_score = t;
            best_out_pos   = 0;
            best_tgt_pos   = 0;
        end else begin
            // strictly greater only: the first maximum keeps its place
            if (o > best_out_score) begin
                best_out_score = o;
                best_out_pos   = elem_pos;
            end
            if (t > best_tgt_score) begin
                best_tgt_score = t;
                best_tgt_pos   = elem_pos;
            end
        end
        diff       = t - o;
        r.gradient = diff[aecg_pkg::GRAD_W-1:0];
        row_done   = (elem_pos + 1 >= len);
        if (row_done) begin
            r.predicted_class = best_out_pos[aecg_pkg::CLASS_W-1:0];
            r.target_class    = best_tgt_pos[aecg_pkg::CLASS_W-1:0];
            r.row_correct     = (best_out_pos == best_tgt_pos);
            if (!r.row_correct && miss_rows < aecg_pkg::COUNT_MAX) miss_rows++;
            batch_done = (row_pos + 1 >= rows);
            elem_pos   = 0;
        end else begin
            elem_pos++;
        end
        r.last_of_row   = row_done;
        r.error_count   = miss_rows[aecg_pkg::CFG_W-1:0];
        r.last_of_batch = batch_done;
        if (row_done) begin
            if (batch_done) begin
                row_pos   = 0;
                miss_rows = 0;
            end else begin
                row_pos++;
            end
        end
        return r;
    endfunction

    function automatic string show(input aecg_pkg::t_out_item r);
        return $sformatf("grad=%0d eor=%0b pred=%0d targ=%0d ok=%0b errs=%0d eob=%0b",
                         r.gradient, r.last_of_row, r.predicted_class, r.target_class,
                         r.row_correct, r.error_count, r.last_of_batch);
    endfunction

    function automatic string diff_fields(input aecg_pkg::t_out_item e,
                                          input aecg_pkg::t_out_item a);
        string s = "";
        if (a.gradient !== e.gradient)               s = {s, " gradient"};
        if (a.last_of_row !== e.last_of_row)         s = {s, " last_of_row"};
        if (a.predicted_class !== e.predicted_class) s = {s, " predicted_class"};
        if (a.target_class !== e.target_class)       s = {s, " target_class"};
        if (a.row_correct !== e.row_correct)         s = {s, " row_correct"};
        if (a.error_count !== e.error_count)         s = {s, " error_count"};
        if (a.last_of_batch !== e.last_of_batch)     s = {s, " last_of_batch"};
        return s;
    endfunction

    always @(posedge i_clk) begin
        aecg_pkg::t_out_item due;
        string               bad;
        if (!i_rst_n) begin
            row_len_reg    = LEN_AT_RESET;
            batch_rows_reg = LEN_AT_RESET;
            best_out_score = 0;
            best_tgt_score = 0;
            best_out_pos   = 0;
            best_tgt_pos   = 0;
            elem_pos       = 0;
            row_pos        = 0;
            miss_rows      = 0;
            results_due.delete();
        end else begin
            // check the result first so a result can never match its own item
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: result with none due: %s", $time, show(i_out));
                end else begin
                    due = results_due.pop_front();
                    bad = diff_fields(due, i_out);
                    if (bad != "") begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("%0t: mismatch in%s", $time, bad);
                            $display("  expected %s", show(due));
                            $display("  actual   %s", show(i_out));
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) results_due.push_back(step_argmax(i_in));
            if (i_cfg_we) begin
                if (i_cfg_index == aecg_pkg::REG_ROW_LENGTH) row_len_reg = i_cfg_data;
                else if (i_cfg_index == aecg_pkg::REG_BATCH_ROWS) batch_rows_reg = i_cfg_data;
            end
        end
        due_count <= results_due.size();
    end

endmodule

// ===== tb/tb_argmax_error_count_with_gradient.sv =====
`timescale 1ns / 100ps
// Testbench top for argmax_error_count_with_gradient: clock, reset, item and
// register stimulus, result back-pressure, watchdog and verdict.
// Depends on aecg_pkg, the block and argmax_error_checker.
module tb_argmax_error_count_with_gradient;

    // Cycles with no item moving on either channel before the run is called hung.
    // The slowest legal stretch is the long receiver hold-off below.
    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 150;
    // a result passes the input and result registers after its item is taken; the
    // drain also lets stray results show up
    localparam int DRAIN_CYCLES = 8;

    // Register indexes the block does not decode; writes there must be ignored.
    localparam logic [aecg_pkg::IDX_W-1:0] REG_SPARE_A  = 2'd2;
    localparam logic [aecg_pkg::IDX_W-1:0] REG_SPARE_B  = 2'd3;
    localparam logic [aecg_pkg::CFG_W-1:0] CFG_ALL_ONES = '1;

    typedef enum logic [1:0] {MIX_FULL, MIX_NARROW, MIX_TRACKED, MIX_EXTREME} t_score_mix;
    typedef enum logic [1:0] {SINK_OPEN, SINK_HALF, SINK_SPARSE, SINK_TOGGLE} t_sink_mode;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    aecg_pkg::t_in_item         in_item   = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    aecg_pkg::t_out_item        out_item;
    logic                       cfg_we    = 1'b0;
    logic [aecg_pkg::IDX_W-1:0] cfg_index = '0;
    logic [aecg_pkg::CFG_W-1:0] cfg_data  = '0;

    int   fail_count;
    int   pending;
    int   quiet_cycles = 0;
    int   burst_left   = 0;
    logic hold_request = 1'b0;

    always #5 clk = ~clk;

    argmax_error_count_with_gradient dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    argmax_error_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Watchdog: count cycles in which no item moves; a hung block ends the run here.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result sink: stall in segments of random mode and length. On request,
    // hold ready low for a long stretch so the block fills and stalls its input.
    initial begin : result_sink
        int         seg_left;
        t_sink_mode mode;
        seg_left = 0;
        mode     = SINK_OPEN;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = t_sink_mode'($urandom_range(0, 3));
                    seg_left = $urandom_range(1, 64);
                end
                seg_left--;
                case (mode)
                    SINK_OPEN:   out_ready <= 1'b1;
                    SINK_HALF:   out_ready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
                    default:     out_ready <= ~out_ready;
                endcase
            end
        end
    end

    function automatic logic [aecg_pkg::SCORE_W-1:0] extreme_score(input int k);
        case (k)
            0:       return 16'h8000;
            1:       return 16'h8001;
            2:       return 16'hFFFF;
            3:       return 16'h0000;
            4:       return 16'h0001;
            5:       return 16'h7FFE;
            default: return 16'h7FFF;
        endcase
    endfunction

    // Draw one element pair. Narrow values force ties; tracked targets copy the
    // output most of the time so whole rows often agree on their argmax.
    function automatic aecg_pkg::t_in_item make_scores(input t_score_mix mix);
        aecg_pkg::t_in_item it;
        case (mix)
            MIX_NARROW: begin
                it.output_score = aecg_pkg::SCORE_W'(int'($urandom_range(0, 6)) - 3);
                it.target_score = aecg_pkg::SCORE_W'(int'($urandom_range(0, 6)) - 3);
            end
            MIX_TRACKED: begin
                it.output_score = aecg_pkg::SCORE_W'($urandom);
                it.target_score = ($urandom_range(0, 3) != 0) ? it.output_score
                                                    : aecg_pkg::SCORE_W'($urandom);
            end
            MIX_EXTREME: begin
                it.output_score = extreme_score($urandom_range(0, 6));
                it.target_score = extreme_score($urandom_range(0, 6));
            end
            default: begin
                it.output_score = aecg_pkg::SCORE_W'($urandom);
                it.target_score = aecg_pkg::SCORE_W'($urandom);
            end
        endcase
        return it;
    endfunction

    // Mostly short rows and batches; now and then zero lengths and oversize batch rows.
    function automatic logic [aecg_pkg::CFG_W-1:0] pick_row_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 11'd1;
            2:       return aecg_pkg::CFG_W'($urandom_range(13, 40));
            default: return aecg_pkg::CFG_W'($urandom_range(2, 12));
        endcase
    endfunction

    function automatic logic [aecg_pkg::CFG_W-1:0] pick_batch_rows();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return 11'd1;
            2:       return CFG_ALL_ONES;
            3:       return 11'd1024;
            4:       return 11'd1025;
            5:       return aecg_pkg::CFG_W'($urandom_range(10, 60));
            default: return aecg_pkg::CFG_W'($urandom_range(2, 6));
        endcase
    endfunction

    // Offer one item and hold it until accepted. The sender runs in bursts;
    // a new burst may open with a random gap, in which valid is dropped.
    task automatic send_item(input aecg_pkg::t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        burst_left--;
    endtask

    task automatic send_pair(input int o, input int t);
        aecg_pkg::t_in_item it;
        it.output_score = aecg_pkg::SCORE_W'(o);
        it.target_score = aecg_pkg::SCORE_W'(t);
        send_item(it);
    endtask

    // Drop valid and wait until every result due has been taken.
    task automatic close_phase();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic random_phase(input int n, input t_score_mix mix);
        repeat (n) send_item(make_scores(mix));
        close_phase();
    endtask

    // Write one register; the block is idle whenever this is called.
    task automatic write_reg(input logic [aecg_pkg::IDX_W-1:0] idx,
                             input logic [aecg_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial begin : stimulus
        int sent_random;
        int phase_no;
        int n;
        sent_random = 0;
        phase_no    = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // At reset lengths (1024 elements per row) start a long row with the
        // score extremes; the gradient reaches +65535 and -65535, and repeated
        // maxima must keep the first position.
        send_pair(-32768, 32767);
        send_pair(32767, -32768);
        send_pair(0, 0);
        send_pair(-1, -1);
        send_pair(32767, 32767);
        send_pair(-32768, -32768);
        close_phase();

        // Lower the row length below the current position: the next item ends the row.
        write_reg(aecg_pkg::REG_ROW_LENGTH, 11'd3);
        send_pair(5, 5);
        close_phase();

        // Zero batch rows acts as one, lowered mid batch; spare indexes are ignored.
        write_reg(aecg_pkg::REG_BATCH_ROWS, '0);
        write_reg(REG_SPARE_A, CFG_ALL_ONES);
        write_reg(REG_SPARE_B, 11'd1);
        send_pair(-1, -1);
        send_pair(-1, -1);
        send_pair(-1, -1);
        close_phase();

        // Zero row length acts as one: every item ends a row.
        write_reg(aecg_pkg::REG_ROW_LENGTH, '0);
        write_reg(aecg_pkg::REG_BATCH_ROWS, 11'd2);
        random_phase(4, MIX_EXTREME);

        // Two-element rows: disagreeing and agreeing argmax, ties in the target.
        write_reg(aecg_pkg::REG_ROW_LENGTH, 11'd2);
        write_reg(aecg_pkg::REG_BATCH_ROWS, 11'd3);
        send_pair(1, 2);
        send_pair(2, 1);
        send_pair(7, 7);
        send_pair(7, 7);
        send_pair(3, -4);
        send_pair(8, -4);
        close_phase();

        // Oversize row length saturates at 1024: one full row and a bit of the next.
        write_reg(aecg_pkg::REG_ROW_LENGTH, CFG_ALL_ONES);
        write_reg(aecg_pkg::REG_BATCH_ROWS, 11'd1);
        random_phase(1030, MIX_FULL);

        // Random phases. Keep a register unchanged now and then so a phase can
        // resume mid row or mid batch, and lower lengths under a running row.
        while (sent_random < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) != 0)
                write_reg(aecg_pkg::REG_ROW_LENGTH, pick_row_length());
            if ($urandom_range(0, 1) != 0)
                write_reg(aecg_pkg::REG_BATCH_ROWS, pick_batch_rows());
            if ($urandom_range(0, 7) == 0)
                write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
                          aecg_pkg::CFG_W'($urandom));
            n = $urandom_range(10, 50);
            // one long receiver hold-off while the sender keeps offering
            if (phase_no == 0) hold_request = 1'b1;
            random_phase(n, t_score_mix'($urandom_range(0, 3)));
            sent_random += n;
            phase_no++;
        end

        // Let any stray result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
